/* rtl/mcpts_pkg.sv */
// ----------------------------------------------------------------------------
// mcpts_pkg: shared types for the periodic tick scheduler
// Step addresses, jump conditions, the control word layout and the
// read-only microprogram that drives the scheduler datapath.
// ----------------------------------------------------------------------------
package mcpts_pkg;

  localparam int STEP_W = 3;

  typedef logic [STEP_W-1:0] step_t;

  // Operation codes of an input word.
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_ADD  = 1'b1;

  // Microprogram addresses.
  localparam step_t STEP_DISPATCH = 3'd0;
  localparam step_t STEP_ADD      = 3'd1;
  localparam step_t STEP_TICK     = 3'd2;
  localparam step_t STEP_READ     = 3'd3;
  localparam step_t STEP_UPDATE   = 3'd4;
  localparam step_t STEP_EMIT     = 3'd5;

  typedef enum logic [2:0] {
    COND_NEXT,      // fall through
    COND_JUMP,      // unconditional jump to target
    COND_DISPATCH,  // wait for start, then branch on the operation
    COND_EMPTY,     // jump to target when no channel is active
    COND_LOOP       // jump to target until the last channel is done
  } cond_t;

  typedef struct packed {
    cond_t cond;
    step_t target;
    logic  do_add;
    logic  do_tick;
    logic  do_read;
    logic  do_update;
    logic  do_emit;
  } ctrl_word_t;

  function automatic ctrl_word_t ucode_rom(input step_t addr);
    ctrl_word_t w;
    w = '{cond: COND_DISPATCH, target: STEP_DISPATCH, default: 1'b0};
    case (addr)
      STEP_DISPATCH: w.cond = COND_DISPATCH;
      STEP_ADD: begin
        w.cond   = COND_JUMP;
        w.target = STEP_DISPATCH;
        w.do_add = 1'b1;
      end
      STEP_TICK: begin
        w.cond    = COND_EMPTY;
        w.target  = STEP_EMIT;
        w.do_tick = 1'b1;
      end
      STEP_READ: begin
        w.cond    = COND_NEXT;
        w.do_read = 1'b1;
      end
      STEP_UPDATE: begin
        w.cond      = COND_LOOP;
        w.target    = STEP_READ;
        w.do_update = 1'b1;
      end
      STEP_EMIT: begin
        w.cond    = COND_JUMP;
        w.target  = STEP_DISPATCH;
        w.do_emit = 1'b1;
      end
      default: w.cond = COND_JUMP;
    endcase
    return w;
  endfunction

endpackage

/* rtl/multi_channel_periodic_tick_scheduler.sv */
// ----------------------------------------------------------------------------
// multi_channel_periodic_tick_scheduler: microcoded periodic timer bank
// Counts ticks and keeps up to NUM_CHANNELS periodic countdown channels.
// ----------------------------------------------------------------------------
// Usage:
//   A word is taken on a rising edge with start high and busy low. With
//   in_operation low the word is a tick; with it high it registers a new
//   channel whose reload period is in_period (slots fill in order, and a
//   registration is refused once all slots are taken).
//   Every word produces exactly one result, shown on the out_ ports for a
//   single cycle while out_strobe is high. The receiver cannot stall; the
//   result is simply presented for that one cycle.
// Timing:
//   A registration keeps busy high for its ADD step only. A tick keeps busy
//   high through the TICK step, one READ/UPDATE step pair per active channel
//   and the EMIT step. The ADD or EMIT step sets the registered out_strobe,
//   which rises as busy falls. The cost comes from the microprogram walking
//   the channel memories one slot per read/update step pair.
// Reset:
//   rst_n is synchronous, active low. It clears the tick count and the
//   number of active channels; the channel memories are not cleared, since
//   only occupied slots are ever read.
// ----------------------------------------------------------------------------
module multi_channel_periodic_tick_scheduler #(
  parameter int NUM_CHANNELS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_operation,
  input  logic [15:0] in_period,
  output logic        out_strobe,
  output logic [7:0]  out_fired_mask,
  output logic [31:0] out_tick_count,
  output logic        out_add_accepted,
  output logic [2:0]  out_channel_index
);

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int CNT_W = $clog2(NUM_CHANNELS + 1);

  mcpts_pkg::ctrl_word_t ctrl;

  // Control state.
  mcpts_pkg::step_t step_r, step_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [31:0]      ticks_r, ticks_nxt;
  logic             out_strobe_r, out_strobe_nxt;

  // Datapath.
  logic [15:0]      period_r;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [7:0]       fired_r, fired_nxt;
  logic [15:0]      rd_cd_r, rd_per_r;
  logic [7:0]       out_fired_r, out_fired_nxt;
  logic [31:0]      out_ticks_r, out_ticks_nxt;
  logic             out_acc_r, out_acc_nxt;
  logic [2:0]       out_idx_r, out_idx_nxt;

  // Memory write port.
  logic             wr_en;
  logic             wr_per_en;
  logic [IDX_W-1:0] wr_addr;
  logic [15:0]      wr_cd_data;

  logic [15:0] per_mem [NUM_CHANNELS];
  logic [15:0] cd_mem  [NUM_CHANNELS];

  logic             full;
  logic             empty;
  logic             last;
  logic [15:0]      cd_dec;
  logic [IDX_W+2:0] idx_ext;
  logic [IDX_W+2:0] slot_ext;

  assign ctrl  = mcpts_pkg::ucode_rom(step_r);
  assign busy  = (step_r != mcpts_pkg::STEP_DISPATCH);
  assign full  = (cnt_r == CNT_W'(NUM_CHANNELS));
  assign empty = (cnt_r == '0);
  assign last  = ((CNT_W'(idx_r) + CNT_W'(1)) == cnt_r);
  assign cd_dec   = rd_cd_r - 16'd1;
  assign idx_ext  = {3'b000, idx_r};
  assign slot_ext = {3'b000, cnt_r[IDX_W-1:0]};

  // Sequencer: next step from the condition field of the control word.
  always_comb begin
    step_nxt = step_r + mcpts_pkg::step_t'(1);
    case (ctrl.cond)
      mcpts_pkg::COND_NEXT: step_nxt = step_r + mcpts_pkg::step_t'(1);
      mcpts_pkg::COND_JUMP: step_nxt = ctrl.target;
      mcpts_pkg::COND_DISPATCH: begin
        if (!start) begin
          step_nxt = step_r;
        end else if (in_operation == mcpts_pkg::OP_ADD) begin
          step_nxt = mcpts_pkg::STEP_ADD;
        end else begin
          step_nxt = mcpts_pkg::STEP_TICK;
        end
      end
      mcpts_pkg::COND_EMPTY: begin
        if (empty) begin
          step_nxt = ctrl.target;
        end
      end
      mcpts_pkg::COND_LOOP: begin
        if (!last) begin
          step_nxt = ctrl.target;
        end
      end
      default: step_nxt = mcpts_pkg::STEP_DISPATCH;
    endcase
  end

  // Datapath actions selected by the control word.
  always_comb begin
    cnt_nxt        = cnt_r;
    ticks_nxt      = ticks_r;
    idx_nxt        = idx_r;
    fired_nxt      = fired_r;
    out_strobe_nxt = 1'b0;
    out_fired_nxt  = out_fired_r;
    out_ticks_nxt  = out_ticks_r;
    out_acc_nxt    = out_acc_r;
    out_idx_nxt    = out_idx_r;
    wr_en          = 1'b0;
    wr_per_en      = 1'b0;
    wr_addr        = idx_r;
    wr_cd_data     = cd_dec;

    if (ctrl.do_add) begin
      out_strobe_nxt = 1'b1;
      out_fired_nxt  = 8'h00;
      out_ticks_nxt  = ticks_r;
      out_acc_nxt    = 1'b0;
      out_idx_nxt    = 3'd0;
      if (!full) begin
        wr_en       = 1'b1;
        wr_per_en   = 1'b1;
        wr_addr     = cnt_r[IDX_W-1:0];
        wr_cd_data  = period_r;
        cnt_nxt     = cnt_r + CNT_W'(1);
        out_acc_nxt = 1'b1;
        out_idx_nxt = slot_ext[2:0];
      end
    end

    if (ctrl.do_tick) begin
      ticks_nxt = ticks_r + 32'd1;
      idx_nxt   = '0;
      fired_nxt = 8'h00;
    end

    if (ctrl.do_update) begin
      wr_en   = 1'b1;
      wr_addr = idx_r;
      idx_nxt = idx_r + IDX_W'(1);
      // A countdown that reaches zero reloads its period and fires.
      if (cd_dec == 16'd0) begin
        wr_cd_data = rd_per_r;
        if (idx_ext < (IDX_W+3)'(8)) begin
          fired_nxt[idx_ext[2:0]] = 1'b1;
        end
      end
    end

    if (ctrl.do_emit) begin
      out_strobe_nxt = 1'b1;
      out_fired_nxt  = fired_r;
      out_ticks_nxt  = ticks_r;
      out_acc_nxt    = 1'b0;
      out_idx_nxt    = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r       <= mcpts_pkg::STEP_DISPATCH;
      cnt_r        <= '0;
      ticks_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      step_r       <= step_nxt;
      cnt_r        <= cnt_nxt;
      ticks_r      <= ticks_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      period_r <= in_period;
    end
    idx_r       <= idx_nxt;
    fired_r     <= fired_nxt;
    out_fired_r <= out_fired_nxt;
    out_ticks_r <= out_ticks_nxt;
    out_acc_r   <= out_acc_nxt;
    out_idx_r   <= out_idx_nxt;
  end

  // Channel memories: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      cd_mem[wr_addr] <= wr_cd_data;
    end
    if (wr_per_en) begin
      per_mem[wr_addr] <= period_r;
    end
    if (ctrl.do_read) begin
      rd_cd_r  <= cd_mem[idx_r];
      rd_per_r <= per_mem[idx_r];
    end
  end

  assign out_strobe        = out_strobe_r;
  assign out_fired_mask    = out_fired_r;
  assign out_tick_count    = out_ticks_r;
  assign out_add_accepted  = out_acc_r;
  assign out_channel_index = out_idx_r;

endmodule

/* tb/sv/tick_scheduler_checker.sv */
// ----------------------------------------------------------------------------
// tick_scheduler_checker: result predictor and comparator
// Watches the word and result channels of the periodic tick scheduler. It
// keeps its own copy of the tick count and the channel slots, predicts the
// result of every accepted word, and compares each strobed result field by
// field against the oldest prediction.
// ----------------------------------------------------------------------------
module tick_scheduler_checker #(
  parameter int NUM_CHANNELS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic        in_operation,
  input  logic [15:0] in_period,
  input  logic        out_strobe,
  input  logic [7:0]  out_fired_mask,
  input  logic [31:0] out_tick_count,
  input  logic        out_add_accepted,
  input  logic [2:0]  out_channel_index,
  output int          fail_count,
  output int          pending_words
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0]  fired;
    logic [31:0] ticks;
    logic        accepted;
    logic [2:0]  slot;
  } sched_result_t;

  logic [31:0]   tick_total;
  int            used_slots;
  logic [15:0]   reload_period [NUM_CHANNELS];
  logic [15:0]   remaining     [NUM_CHANNELS];
  sched_result_t result_q [$];

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("[%0t] mismatch in %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
    fail_count++;
  endtask

  // Advances the scheduler state by one word and returns its result.
  function automatic sched_result_t apply_word(input logic op, input logic [15:0] per);
    sched_result_t r;
    r = '0;
    if (op == mcpts_pkg::OP_ADD) begin
      if (used_slots < NUM_CHANNELS) begin
        reload_period[used_slots] = per;
        remaining[used_slots]     = per;
        r.accepted = 1'b1;
        r.slot     = used_slots[2:0];
        used_slots++;
      end
    end else begin
      tick_total++;
      for (int i = 0; i < used_slots; i++) begin
        // A zero period wraps through 65535, so it fires once per 65536 ticks.
        remaining[i] = remaining[i] - 16'd1;
        if (remaining[i] == 16'd0) begin
          remaining[i] = reload_period[i];
          if (i < 8) r.fired[i[2:0]] = 1'b1;
        end
      end
    end
    r.ticks = tick_total;
    return r;
  endfunction

  always @(posedge clk) begin
    sched_result_t want;
    if (!rst_n) begin
      tick_total = '0;
      used_slots = 0;
      result_q.delete();
    end else begin
      if (out_strobe) begin
        if (result_q.size() == 0) begin
          report_mismatch("unexpected result word", 32'd0, 32'd1);
        end else begin
          want = result_q.pop_front();
          if (out_fired_mask !== want.fired)
            report_mismatch("fired_mask", 32'(want.fired), 32'(out_fired_mask));
          if (out_tick_count !== want.ticks)
            report_mismatch("tick_count", want.ticks, out_tick_count);
          if (out_add_accepted !== want.accepted)
            report_mismatch("add_accepted", 32'(want.accepted), 32'(out_add_accepted));
          if (out_channel_index !== want.slot)
            report_mismatch("channel_index", 32'(want.slot), 32'(out_channel_index));
        end
      end
      if (start && !busy) result_q.push_back(apply_word(in_operation, in_period));
    end
    pending_words <= result_q.size();
  end

endmodule

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: regression bench for the periodic tick scheduler
// Resets the scheduler once, registers channels with extreme and random
// periods, then sends random ticks and refused registrations under varying
// sender idling. The checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 5000;
  localparam int PHASE_WORDS = 450;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        in_operation = mcpts_pkg::OP_TICK;
  logic [15:0] in_period = '0;
  logic        busy;
  logic        out_strobe;
  logic [7:0]  out_fired_mask;
  logic [31:0] out_tick_count;
  logic        out_add_accepted;
  logic [2:0]  out_channel_index;
  int          fail_count;
  int          pending_words;
  int          gap_pct = 17;
  int unsigned stall_cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  multi_channel_periodic_tick_scheduler DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_operation      (in_operation),
    .in_period         (in_period),
    .out_strobe        (out_strobe),
    .out_fired_mask    (out_fired_mask),
    .out_tick_count    (out_tick_count),
    .out_add_accepted  (out_add_accepted),
    .out_channel_index (out_channel_index)
  );

  tick_scheduler_checker sched_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_operation      (in_operation),
    .in_period         (in_period),
    .out_strobe        (out_strobe),
    .out_fired_mask    (out_fired_mask),
    .out_tick_count    (out_tick_count),
    .out_add_accepted  (out_add_accepted),
    .out_channel_index (out_channel_index),
    .fail_count        (fail_count),
    .pending_words     (pending_words)
  );

  // Presents one word, dropping start on random cycles, until it is taken.
  task automatic send_word(input logic op, input logic [15:0] per);
    logic taken;
    taken = 1'b0;
    in_operation <= op;
    in_period    <= per;
    while (!taken) begin
      if ($urandom_range(99) < gap_pct) begin
        start <= 1'b0;
        @(posedge clk);
      end else begin
        start <= 1'b1;
        @(posedge clk);
        taken = !busy;
      end
    end
  endtask

  always @(posedge clk) begin
    if ((start && !busy) || out_strobe) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("multi_channel_periodic_tick_scheduler regression: fail");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // A tick with no channel registered; the period must be ignored.
    send_word(mcpts_pkg::OP_TICK, 16'hFFFF);
    send_word(mcpts_pkg::OP_ADD, 16'h0000);
    send_word(mcpts_pkg::OP_ADD, 16'h0001);
    send_word(mcpts_pkg::OP_ADD, 16'hFFFF);
    send_word(mcpts_pkg::OP_TICK, 16'h0000);
    send_word(mcpts_pkg::OP_ADD, 16'h0002);
    send_word(mcpts_pkg::OP_ADD, 16'hAAAA);
    send_word(mcpts_pkg::OP_TICK, 16'h5555);
    repeat (3) send_word(mcpts_pkg::OP_ADD, 16'($urandom_range(40, 1)));
    // Every slot is taken now, so this registration is refused.
    send_word(mcpts_pkg::OP_ADD, 16'h5555);
    repeat (4) send_word(mcpts_pkg::OP_TICK, 16'($urandom));

    for (int phase = 0; phase < 3; phase++) begin
      gap_pct = (phase == 0) ? 17 : (phase == 1) ? 68 : 0;
      repeat (PHASE_WORDS)
        send_word(($urandom_range(99) < 20) ? mcpts_pkg::OP_ADD : mcpts_pkg::OP_TICK,
                  16'($urandom));
    end
    start <= 1'b0;

    while (pending_words != 0) @(posedge clk);
    repeat (32) @(posedge clk);
    if (fail_count == 0) begin
      $display("multi_channel_periodic_tick_scheduler regression: pass");
    end else begin
      $display("multi_channel_periodic_tick_scheduler regression: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/mcpts_pkg.sv
rtl/multi_channel_periodic_tick_scheduler.sv
tb/sv/tick_scheduler_checker.sv
tb/sv/tb_top.sv
